[design/rc5e_pkg.sv]
`default_nettype none

package rc5e_pkg;

	localparam int unsigned FRAME_BITS_DEF = 13;
	localparam logic [7:0] GAP_TICKS_RST = 8'd100;
	localparam logic [15:0] TOGGLE_CLR_MASK = 16'hF7FF;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_SEND   = 2'd1;
	localparam logic [1:0] CMD_REPEAT = 2'd2;
	localparam logic [1:0] CMD_STOP   = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] code;
	} req_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
	} rsp_t;

endpackage

`default_nettype wire

[design/rc5e_engine.sv]
`default_nettype none

module rc5e_engine import rc5e_pkg::*; #(
	parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire req_t       item,
	input  wire logic [7:0] gap_ticks,
	output rsp_t            result
);

	localparam int unsigned CW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START_A,
		PH_START_B,
		PH_BIT_A,
		PH_BIT_B,
		PH_GAP
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [FRAME_BITS-1:0]   shift_q, shift_d;
	logic [CW-1:0]           bits_q, bits_d;
	logic [7:0]              wait_q, wait_d;
	logic                    toggle_q, toggle_d;
	logic [15:0]             held_q, held_d;
	logic                    carrier_q, carrier_d;
	logic [CW:0]             bits_nxt;
	logic [8:0]              wait_nxt;

	assign bits_nxt = {1'b0, bits_q} + {{CW{1'b0}}, 1'b1};
	assign wait_nxt = {1'b0, wait_q} + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		shift_d   = shift_q;
		bits_d    = bits_q;
		wait_d    = wait_q;
		toggle_d  = toggle_q;
		held_d    = held_q;
		carrier_d = carrier_q;
		unique case (item.cmd)
			CMD_TICK: begin
				unique case (phase_q)
					PH_START_A: begin
						carrier_d = 1'b0;
						phase_d   = PH_START_B;
					end
					PH_START_B: begin
						carrier_d = 1'b1;
						phase_d   = PH_BIT_A;
					end
					PH_BIT_A: begin
						// a one goes out as off then on
						carrier_d = ~shift_q[FRAME_BITS-1];
						shift_d   = shift_q << 1;
						phase_d   = PH_BIT_B;
					end
					PH_BIT_B: begin
						carrier_d = ~carrier_q;
						if (bits_nxt >= (CW+1)'(FRAME_BITS)) begin
							bits_d  = '0;
							phase_d = PH_GAP;
						end else begin
							bits_d  = bits_nxt[CW-1:0];
							phase_d = PH_BIT_A;
						end
					end
					PH_GAP: begin
						carrier_d = 1'b0;
						if (wait_nxt >= {1'b0, gap_ticks}) begin
							wait_d  = '0;
							bits_d  = '0;
							phase_d = PH_IDLE;
						end else begin
							wait_d = wait_nxt[7:0];
						end
					end
					default: begin
						carrier_d = 1'b0;
						phase_d   = PH_IDLE;
					end
				endcase
			end
			CMD_SEND, CMD_REPEAT: begin
				if (item.cmd == CMD_SEND) begin
					held_d = toggle_q ? (item.code & TOGGLE_CLR_MASK) : item.code;
				end
				if (held_d != 16'd0 && phase_q == PH_IDLE) begin
					shift_d = held_d[FRAME_BITS-1:0];
					phase_d = PH_START_A;
				end
			end
			default: begin
				toggle_d = ~toggle_q;
				held_d   = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			shift_q   <= '0;
			bits_q    <= '0;
			wait_q    <= '0;
			toggle_q  <= 1'b0;
			held_q    <= '0;
			carrier_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			shift_q   <= shift_d;
			bits_q    <= bits_d;
			wait_q    <= wait_d;
			toggle_q  <= toggle_d;
			held_q    <= held_d;
			carrier_q <= carrier_d;
		end
	end

	assign result.carrier_on = carrier_d;
	assign result.busy_res   = (phase_d != PH_IDLE);

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, bits_q} < (CW+1)'(FRAME_BITS))
		else $error("bit counter past frame length");
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !carrier_q)
		else $error("carrier on while idle");
	a_gap_dark: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GAP && step && item.cmd == CMD_TICK |=> !carrier_q)
		else $error("carrier on after gap tick");

endmodule

`default_nettype wire

[design/rc5_ir_frame_encoder_core.sv]
// Infrared remote frame encoder (Manchester, start pair plus frame bits plus gap).
//
// Channels: req (valid/ready) carries one event transaction: cmd tick, send,
// repeat or stop, and a 16-bit code used by send. rsp (valid/ready) returns one
// transaction per event: the carrier level and busy flag after the event.
// cfg_we/cfg_data write gap_ticks; write only while idle.
//
// Pipeline: an accepted request is captured in the input register, processed by
// the frame state machine when the output register is free or being drained,
// and its response is registered. Throughput: one transaction per cycle while
// rsp is taken, set by the combinational state update between the registers.
//
// Reset: the engine state clears, gap_ticks returns to 100, both registers empty.
// Stall: while rsp is held by the receiver the input register still accepts
// one more request; then req_ready drops until the response is taken.
`default_nettype none

module rc5_ir_frame_encoder_core import rc5e_pkg::*; #(
	parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data
);

	logic [7:0] gap_q;
	logic       s1_valid_q;
	req_t       req_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       advance;
	rsp_t       result;

	// advance the held event when the output register is free or being drained
	assign advance   = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_TICKS_RST;
		end else if (cfg_we) begin
			gap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_ready) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	rc5e_engine #(
		.FRAME_BITS(FRAME_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (req_s1),
		.gap_ticks(gap_q),
		.result   (result)
	);

	// hold the response until taken; drop valid once drained with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp_ready) begin
			rsp_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> req_ready)
		else $error("input register empty but not ready");
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(s1_valid_q))
		else $error("response without a pending event");
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.busy_res |-> !rsp.carrier_on)
		else $error("carrier reported on while not busy");

endmodule

`default_nettype wire

[sim/rc5_ir_frame_encoder_core_tb.sv]
`timescale 1ns / 100ps

module rc5_ir_frame_encoder_core_tb;
	import rc5e_pkg::*;

	localparam int FB = FRAME_BITS_DEF;
	// Cycles with no transaction on either channel before the run is called hung.
	// The worst case is one side idling 82 percent of the time, so short quiet
	// runs happen; runs anywhere near the limit do not.
	localparam int QUIET_LIMIT = 3000;
	// Pause after the last response before a register write or the final verdict.
	localparam int SETTLE_CYCLES = 6;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_START_A = 3'd1,
		PH_START_B = 3'd2,
		PH_BIT_A   = 3'd3,
		PH_BIT_B   = 3'd4,
		PH_GAP     = 3'd5
	} frame_phase_t;

	// Tracks the encoder's frame state and holds the carrier/busy pairs
	// that the block still owes, oldest first.
	class rc5_frame_scoreboard;
		rsp_t          level_q[$];
		frame_phase_t  phase;
		logic [FB-1:0] shift_word;
		logic [3:0]    bits_sent;
		logic [7:0]    wait_count;
		logic [7:0]    gap_ticks;
		logic          toggle_flag;
		logic [15:0]   held_code;
		logic          carrier;
		int            mismatches;

		function new();
			phase = PH_IDLE;
			shift_word = '0;
			bits_sent = '0;
			wait_count = '0;
			gap_ticks = GAP_TICKS_RST;
			toggle_flag = 1'b0;
			held_code = '0;
			carrier = 1'b0;
			mismatches = 0;
		endfunction

		function void set_gap(logic [7:0] value);
			gap_ticks = value;
		endfunction

		function bit frame_active();
			return phase != PH_IDLE;
		endfunction

		function int pending();
			return level_q.size();
		endfunction

		function void advance_half_bit();
			case (phase)
				PH_START_A: begin
					carrier = 1'b0;
					phase = PH_START_B;
				end
				PH_START_B: begin
					carrier = 1'b1;
					phase = PH_BIT_A;
				end
				PH_BIT_A: begin
					// a one goes out as off then on
					carrier = ~shift_word[FB-1];
					shift_word = shift_word << 1;
					phase = PH_BIT_B;
				end
				PH_BIT_B: begin
					carrier = ~carrier;
					if (int'(bits_sent) + 1 >= FB) begin
						bits_sent = '0;
						phase = PH_GAP;
					end else begin
						bits_sent = bits_sent + 4'd1;
						phase = PH_BIT_A;
					end
				end
				PH_GAP: begin
					carrier = 1'b0;
					// a gap of zero ends after one tick, same as a gap of one
					if (int'(wait_count) + 1 >= int'(gap_ticks)) begin
						wait_count = '0;
						bits_sent = '0;
						phase = PH_IDLE;
					end else begin
						wait_count = wait_count + 8'd1;
					end
				end
				default: begin
					carrier = 1'b0;
					phase = PH_IDLE;
				end
			endcase
		endfunction

		function void try_start();
			if (held_code != '0 && phase == PH_IDLE) begin
				shift_word = held_code[FB-1:0];
				phase = PH_START_A;
			end
		endfunction

		function void note_event(req_t item);
			rsp_t due;
			case (item.cmd)
				CMD_TICK: advance_half_bit();
				CMD_SEND: begin
					held_code = item.code;
					if (toggle_flag)
						held_code = held_code & TOGGLE_CLR_MASK;
					try_start();
				end
				CMD_REPEAT: try_start();
				default: begin
					toggle_flag = ~toggle_flag;
					held_code = '0;
				end
			endcase
			due.carrier_on = carrier;
			due.busy_res = (phase != PH_IDLE);
			level_q.push_back(due);
		endfunction

		function void check_level(rsp_t got);
			rsp_t due;
			if (level_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: carrier_on=%b busy_res=%b",
						got.carrier_on, got.busy_res);
				return;
			end
			due = level_q.pop_front();
			if (got.carrier_on !== due.carrier_on || got.busy_res !== due.busy_res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected carrier %b busy %b, got carrier %b busy %b",
						due.carrier_on, due.busy_res, got.carrier_on, got.busy_res);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;
	logic       cfg_we;
	logic [7:0] cfg_data;

	rc5_frame_scoreboard sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int events_sent;
	int quiet_cycles = 0;

	rc5_ir_frame_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: drop ready at random, at the rate the current traffic mode sets.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample the response channel at the edge. Every input is driven by
	// nonblocking assignment, so the values seen here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_level(rsp);
	end

	// Watchdog: count cycles in which no transaction moves on either channel.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Present one event and hold it until the block takes it. Idle cycles
	// before it are drawn at the sender's rate; valid is never lowered and
	// raised in the same step.
	task automatic issue_event(input logic [1:0] cmd, input logic [15:0] code);
		req_t item;
		item.cmd = cmd;
		item.code = code;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		// note the transaction right at its edge, before any response to it can land
		sb.note_event(item);
		events_sent++;
	endtask

	// Hold the sender until every owed response has come back.
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Tick until the running frame and its gap are over.
	task automatic finish_frame();
		while (sb.frame_active())
			issue_event(CMD_TICK, 16'($urandom));
	endtask

	// Write gap_ticks with the block idle: no frame running, nothing in flight.
	task automatic write_gap(input logic [7:0] value);
		finish_frame();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_gap(value);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(3))
			0: return 16'($urandom);
			// bit 11 set, so the toggle clear shows
			1: return 16'($urandom) | 16'h0800;
			// only bits above the frame set: a frame of zeros goes out
			2: return {3'($urandom_range(1, 7)), 13'h0};
			default: return 16'($urandom_range(1, 8191));
		endcase
	endfunction

	// Mostly whole frames with random content, then noise: stray commands
	// while busy, stops, lone events of any kind.
	task automatic run_traffic(input int budget);
		int stop_at;
		int pick;
		stop_at = events_sent + budget;
		while (events_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if ($urandom_range(4) == 0)
					issue_event(CMD_REPEAT, 16'($urandom));
				else
					issue_event(CMD_SEND, pick_code());
				while (sb.frame_active()) begin
					if ($urandom_range(99) < 6)
						issue_event(2'($urandom_range(1, 3)), 16'($urandom));
					else
						issue_event(CMD_TICK, 16'($urandom));
				end
				if ($urandom_range(4) == 0)
					issue_event(CMD_STOP, 16'($urandom));
			end else begin
				issue_event(2'($urandom), 16'($urandom));
			end
			if ($urandom_range(39) == 0)
				hold_until_drained();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		events_sent = 0;
		send_idle_pct = 20;
		recv_idle_pct = 82;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, gap at its reset value.
		issue_event(CMD_TICK, 16'hFFFF);    // tick while idle
		issue_event(CMD_REPEAT, 16'h0000);  // repeat with nothing held
		issue_event(CMD_SEND, 16'h0000);    // zero code starts nothing
		issue_event(CMD_STOP, 16'hFFFF);    // toggle goes odd
		issue_event(CMD_SEND, 16'hFFFF);    // bit 11 cleared, frame starts
		issue_event(CMD_SEND, 16'h5A5A);    // send while busy: stored only
		issue_event(CMD_REPEAT, 16'h0000);  // repeat while busy
		repeat (8) issue_event(CMD_TICK, 16'h0000);
		issue_event(CMD_STOP, 16'h0000);    // running frame must still finish
		repeat (4) issue_event(CMD_TICK, 16'hFFFF);
		finish_frame();
		issue_event(CMD_REPEAT, 16'h0000);  // held code was cleared by stop

		// Smallest gap, zero: behaves as one tick.
		write_gap(8'd0);
		issue_event(CMD_SEND, 16'hE000);    // only bits above the frame set
		finish_frame();
		issue_event(CMD_STOP, 16'h0000);    // toggle odd again
		issue_event(CMD_SEND, 16'h0800);    // clears to zero, no frame
		issue_event(CMD_REPEAT, 16'h0000);
		issue_event(CMD_SEND, 16'h1FFF);    // all frame bits one
		finish_frame();
		run_traffic(100);

		// Sender slow, receiver fast.
		send_idle_pct = 82;
		recv_idle_pct = 20;
		write_gap(8'd40);
		run_traffic(50);
		write_gap(8'd3);
		run_traffic(30);

		// Neither side idles.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_gap(8'($urandom_range(1, 20)));
		run_traffic(70);

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
